// ===== hdl/tfpc8_pkg.sv =====
// Shared constants, types and the CRC-8 byte update for the frame parser.
package tfpc8_pkg;

   localparam int unsigned HEADER_BYTES = 10;
   localparam int unsigned MAX_PAYLOAD  = 255;

   localparam int unsigned LEN_W = 9;
   localparam logic [7:0]  CRC_POLY = 8'h07;

   localparam logic [15:0]      LEN_MIN    = 16'(HEADER_BYTES);
   localparam logic [15:0]      LEN_MAX    = 16'(HEADER_BYTES + MAX_PAYLOAD);
   localparam logic [LEN_W-1:0] LEN_MIN_S  = LEN_W'(HEADER_BYTES);
   localparam logic [LEN_W-1:0] LEN_MAX_S  = LEN_W'(HEADER_BYTES + MAX_PAYLOAD);

   // event codes
   localparam logic [1:0] EVT_NONE     = 2'd0;
   localparam logic [1:0] EVT_PAYLOAD  = 2'd1;
   localparam logic [1:0] EVT_CRC_GOOD = 2'd2;
   localparam logic [1:0] EVT_CRC_BAD  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SYNC_VALUE   = 2'd0;
   localparam logic [1:0] CSR_TYPE_MASK    = 2'd1;
   localparam logic [1:0] CSR_TYPE_VERSION = 2'd2;

   localparam logic [7:0] SYNC_VALUE_RST   = 8'd60;
   localparam logic [7:0] TYPE_MASK_RST    = 8'd248;
   localparam logic [7:0] TYPE_VERSION_RST = 8'd32;

   typedef struct packed {
      logic [7:0] sync_value;
      logic [7:0] type_mask;
      logic [7:0] type_version;
   } csr_type;

   typedef struct packed {
      logic [1:0]       event_kind;
      logic [7:0]       payload_byte;
      logic [7:0]       payload_index;
      logic [7:0]       frame_type;
      logic [LEN_W-1:0] frame_length;
      logic [31:0]      object_id;
      logic [15:0]      instance_id;
   } result_type;

   // CRC-8, MSB first, no reflection, no final xor
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
      end
      return v;
   endfunction

endpackage

// ===== hdl/telemetry_frame_parser_crc8_core.sv =====
// Top level of the sync/length framed telemetry parser with CRC-8 check.
//
// Takes one received byte per req beat and returns exactly one rsp beat for
// it. The parser hunts for the sync byte, checks the masked type byte against
// the configured version, reads a little-endian 16-bit length (kept only if
// it lies in 10..265), a 32-bit object id and a 16-bit instance id, then
// passes payload bytes out with their index (event 1). The byte after the
// payload is compared against the CRC-8 (poly 0x07, init 0, MSB first) of all
// earlier frame bytes, sync included, giving event 2 (match) or 3 (mismatch)
// with the frame header fields. Everything else reports event 0 with zero
// fields. Rate: one beat per clock while req_ready is high (result register
// empty or draining). Each byte's parse step is a single pass of logic from
// the parser state registers into the result register, so rsp_valid rises
// in the cycle after accept. The user must write configuration registers
// (index 0 sync value, 1 type mask, 2 type version) via the csr port only
// while idle; the block does not enforce it; other indexes are ignored.
module telemetry_frame_parser_crc8_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_frame_type,
   output logic [8:0]  rsp_frame_length,
   output logic [31:0] rsp_object_id,
   output logic [15:0] rsp_instance_id
);
   import tfpc8_pkg::*;

   csr_type    csr_ff;
   csr_type    csr_in;
   logic       has_room;
   logic       beat;
   result_type result;
   result_type rsp_data;

   // config register file, plain write-only
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SYNC_VALUE:   csr_in.sync_value   = csr_write_data;
            CSR_TYPE_MASK:    csr_in.type_mask    = csr_write_data;
            CSR_TYPE_VERSION: csr_in.type_version = csr_write_data;
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sync_value   <= SYNC_VALUE_RST;
         csr_ff.type_mask    <= TYPE_MASK_RST;
         csr_ff.type_version <= TYPE_VERSION_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // a req beat moves whenever the result register can take its answer
   assign req_ready = has_room;
   assign beat      = req_valid && has_room;

   tfpc8_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .beat_valid (beat),
      .rx_byte    (req_rx_byte),
      .result     (result)
   );

   tfpc8_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (beat),
      .result    (result),
      .rsp_ready (rsp_ready),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_event_kind    = rsp_data.event_kind;
   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_payload_index = rsp_data.payload_index;
   assign rsp_frame_type    = rsp_data.frame_type;
   assign rsp_frame_length  = rsp_data.frame_length;
   assign rsp_object_id     = rsp_data.object_id;
   assign rsp_instance_id   = rsp_data.instance_id;

endmodule

// ===== hdl/tfpc8_parser.sv =====
// Frame parse state machine: field capture, CRC accumulation and result build.
module tfpc8_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  tfpc8_pkg::csr_type   csr,
   input  logic                 beat_valid,
   input  logic [7:0]           rx_byte,
   output tfpc8_pkg::result_type result
);
   import tfpc8_pkg::*;

   typedef enum logic [6:0] {
      PH_HUNT     = 7'b0000001,
      PH_TYPE     = 7'b0000010,
      PH_LENGTH   = 7'b0000100,
      PH_OBJECT   = 7'b0001000,
      PH_INSTANCE = 7'b0010000,
      PH_PAYLOAD  = 7'b0100000,
      PH_CRC      = 7'b1000000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       cnt_ff, cnt_in;
   logic [7:0]       type_ff, type_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [31:0]      obj_ff, obj_in;
   logic [15:0]      inst_ff, inst_in;

   logic [15:0]      full_len;
   logic [LEN_W-1:0] cnt_next;
   logic [LEN_W-1:0] data_len;

   assign full_len = {rx_byte, len_ff[7:0]};
   assign cnt_next = {1'b0, cnt_ff} + LEN_W'(1);
   assign data_len = len_ff - LEN_MIN_S;

   always_comb begin
      phase_in = phase_ff;
      crc_in   = crc_ff;
      cnt_in   = cnt_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      obj_in   = obj_ff;
      inst_in  = inst_ff;
      result   = '0;
      if (beat_valid) begin
         unique case (phase_ff)
            PH_TYPE: begin
               crc_in = crc8_next(crc_ff, rx_byte);
               if ((rx_byte & csr.type_mask) == csr.type_version) begin
                  type_in  = rx_byte;
                  cnt_in   = '0;
                  phase_in = PH_LENGTH;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LENGTH: begin
               crc_in = crc8_next(crc_ff, rx_byte);
               if (cnt_ff == 8'd0) begin
                  len_in = {1'b0, rx_byte};
                  cnt_in = 8'd1;
               end else if (full_len < LEN_MIN || full_len > LEN_MAX) begin
                  phase_in = PH_HUNT;
               end else begin
                  len_in   = full_len[LEN_W-1:0];
                  cnt_in   = '0;
                  phase_in = PH_OBJECT;
               end
            end
            PH_OBJECT: begin
               crc_in = crc8_next(crc_ff, rx_byte);
               obj_in[8*cnt_ff[1:0] +: 8] = rx_byte;
               if (cnt_ff[1:0] == 2'd3) begin
                  cnt_in   = '0;
                  phase_in = PH_INSTANCE;
               end else begin
                  cnt_in = cnt_ff + 8'd1;
               end
            end
            PH_INSTANCE: begin
               crc_in = crc8_next(crc_ff, rx_byte);
               if (cnt_ff == 8'd0) begin
                  inst_in[7:0] = rx_byte;
                  cnt_in       = 8'd1;
               end else begin
                  inst_in[15:8] = rx_byte;
                  cnt_in        = '0;
                  // header-only frame goes straight to the CRC byte
                  phase_in = (len_ff == LEN_MIN_S) ? PH_CRC : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in               = crc8_next(crc_ff, rx_byte);
               result.event_kind    = EVT_PAYLOAD;
               result.payload_byte  = rx_byte;
               result.payload_index = cnt_ff;
               if (cnt_next >= data_len) begin
                  cnt_in   = '0;
                  phase_in = PH_CRC;
               end else begin
                  cnt_in = cnt_ff + 8'd1;
               end
            end
            PH_CRC: begin
               result.event_kind   = (rx_byte == crc_ff) ? EVT_CRC_GOOD : EVT_CRC_BAD;
               result.frame_type   = type_ff;
               result.frame_length = len_ff;
               result.object_id    = obj_ff;
               result.instance_id  = inst_ff;
               phase_in            = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
               if (rx_byte == csr.sync_value) begin
                  crc_in   = crc8_next(8'h00, rx_byte);
                  phase_in = PH_TYPE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      type_ff <= type_in;
      len_ff  <= len_in;
      obj_ff  <= obj_in;
      inst_ff <= inst_in;
   end

   a_crc_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (beat_valid && phase_ff == PH_CRC) |=> (phase_ff == PH_HUNT))
      else $error("parser did not return to hunt after CRC byte");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OBJECT || phase_ff == PH_INSTANCE ||
       phase_ff == PH_PAYLOAD || phase_ff == PH_CRC)
      |-> (len_ff >= LEN_MIN_S && len_ff <= LEN_MAX_S))
      else $error("frame length out of range past length check");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (cnt_next <= data_len))
      else $error("payload index past data length");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      (beat_valid && phase_ff == PH_INSTANCE && cnt_ff != 8'd0 && len_ff == LEN_MIN_S)
      |=> (phase_ff == PH_CRC))
      else $error("header-only frame did not skip payload");

endmodule

// ===== hdl/tfpc8_rsp_reg.sv =====
// Result register with its valid flag; frees up when the sink takes the beat.
module tfpc8_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tfpc8_pkg::result_type result,
   input  logic                  rsp_ready,
   output logic                  has_room,
   output logic                  rsp_valid,
   output tfpc8_pkg::result_type rsp_data
);
   import tfpc8_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign has_room = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the sync/length framed telemetry parser with CRC-8.
`timescale 1ns / 100ps

module testbench;
   import tfpc8_pkg::*;

   // Register index past the end of the list; writes to it must be ignored.
   localparam logic [1:0] CSR_SPARE = 2'd3;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int unsigned HANG_LIMIT = 4000;
   // Mismatch lines printed before the report goes quiet (all are still counted).
   localparam int unsigned REPORT_CAP = 40;

   // Parser position in the frame, as the predictor tracks it.
   typedef enum logic [2:0] {
      HUNT_SYNC, TAKE_TYPE, TAKE_LENGTH, TAKE_OBJECT, TAKE_INSTANCE,
      TAKE_PAYLOAD, TAKE_CRC
   } parse_phase_type;

   // Handshake pacing of one traffic phase.
   typedef enum logic [1:0] {
      PACE_STEADY, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH
   } pace_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_write_en   = 1'b0;
   logic [1:0]  csr_index      = CSR_SYNC_VALUE;
   logic [7:0]  csr_write_data = 8'h00;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte    = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_payload_index;
   logic [7:0]  rsp_frame_type;
   logic [8:0]  rsp_frame_length;
   logic [31:0] rsp_object_id;
   logic [15:0] rsp_instance_id;

   telemetry_frame_parser_crc8_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_object_id     (rsp_object_id),
      .rsp_instance_id   (rsp_instance_id)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state. Only the monitor process below touches it.
   // ------------------------------------------------------------------
   parse_phase_type phase_now;
   logic [7:0]   crc_acc;
   logic [7:0]   field_cnt;
   logic [7:0]   held_type;
   logic [15:0]  held_len;
   logic [31:0]  held_obj;
   logic [15:0]  held_inst;
   // Register values as the block sees them on the csr port.
   logic [7:0]   seen_sync;
   logic [7:0]   seen_mask;
   logic [7:0]   seen_version;

   result_type   pending_status[$];   // expected rsp beats, oldest first
   result_type   due;

   // Register values the stimulus builds frames for.
   logic [7:0]   cur_sync    = SYNC_VALUE_RST;
   logic [7:0]   cur_mask    = TYPE_MASK_RST;
   logic [7:0]   cur_version = TYPE_VERSION_RST;

   pace_type     pace = PACE_STEADY;
   int unsigned  bytes_sent;
   int unsigned  mismatches;
   int unsigned  payload_beats;
   int unsigned  frames_good;
   int unsigned  frames_bad;
   int unsigned  settings_used;
   int unsigned  quiet_cycles;

   // Bit-serial CRC-8, poly 0x07, MSB first: feedback is the top bit xor
   // the incoming data bit.
   function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] s;
      int         i;
      s = acc;
      for (i = 7; i >= 0; i--) begin
         s = {s[6:0], 1'b0} ^ ((s[7] ^ d[i]) ? CRC_POLY : 8'h00);
      end
      return s;
   endfunction

   // Advances the parser model by one byte and returns the status beat
   // that byte must produce.
   function automatic result_type predict_status(input logic [7:0] c);
      result_type r;
      r = '0;
      case (phase_now)
         TAKE_TYPE: begin
            crc_acc = crc_update(crc_acc, c);
            if ((c & seen_mask) == seen_version) begin
               held_type = c;
               field_cnt = 8'd0;
               phase_now = TAKE_LENGTH;
            end else begin
               phase_now = HUNT_SYNC;   // wrong version, drop frame
            end
         end
         TAKE_LENGTH: begin
            crc_acc   = crc_update(crc_acc, c);
            field_cnt = field_cnt + 8'd1;
            if (field_cnt < 8'd2) begin
               held_len = {8'h00, c};
            end else begin
               held_len[15:8] = c;
               if (held_len < LEN_MIN || held_len > LEN_MAX) begin
                  phase_now = HUNT_SYNC;
               end else begin
                  field_cnt = 8'd0;
                  phase_now = TAKE_OBJECT;
               end
            end
         end
         TAKE_OBJECT: begin
            crc_acc   = crc_update(crc_acc, c);
            field_cnt = field_cnt + 8'd1;
            if (field_cnt == 8'd1) begin
               held_obj = {24'h000000, c};
            end else begin
               held_obj[8*(field_cnt-8'd1) +: 8] = c;
               if (field_cnt >= 8'd4) begin
                  field_cnt = 8'd0;
                  phase_now = TAKE_INSTANCE;
               end
            end
         end
         TAKE_INSTANCE: begin
            crc_acc   = crc_update(crc_acc, c);
            field_cnt = field_cnt + 8'd1;
            if (field_cnt == 8'd1) begin
               held_inst = {8'h00, c};
            end else begin
               held_inst[15:8] = c;
               field_cnt = 8'd0;
               // header-only frame goes straight to the CRC byte
               phase_now = (held_len == LEN_MIN) ? TAKE_CRC : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            crc_acc         = crc_update(crc_acc, c);
            r.event_kind    = EVT_PAYLOAD;
            r.payload_byte  = c;
            r.payload_index = field_cnt;
            field_cnt       = field_cnt + 8'd1;
            if ({8'h00, field_cnt} >= held_len - LEN_MIN) begin
               field_cnt = 8'd0;
               phase_now = TAKE_CRC;
            end
         end
         TAKE_CRC: begin
            r.event_kind = (c == crc_acc) ? EVT_CRC_GOOD : EVT_CRC_BAD;
            phase_now    = HUNT_SYNC;
         end
         default: begin
            phase_now = HUNT_SYNC;
            if (c == seen_sync) begin
               crc_acc   = crc_update(8'h00, c);
               phase_now = TAKE_TYPE;
            end
         end
      endcase
      if (r.event_kind == EVT_CRC_GOOD || r.event_kind == EVT_CRC_BAD) begin
         r.frame_type   = held_type;
         r.frame_length = held_len[LEN_W-1:0];
         r.object_id    = held_obj;
         r.instance_id  = held_inst;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: mirrors csr writes, predicts on each req beat, checks each
   // rsp beat against the oldest prediction. Runs on pre-edge values.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         phase_now    = HUNT_SYNC;
         crc_acc      = 8'h00;
         field_cnt    = 8'h00;
         held_type    = 8'h00;
         held_len     = 16'h0000;
         held_obj     = 32'h0;
         held_inst    = 16'h0000;
         seen_sync    = SYNC_VALUE_RST;
         seen_mask    = TYPE_MASK_RST;
         seen_version = TYPE_VERSION_RST;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SYNC_VALUE:   seen_sync    = csr_write_data;
               CSR_TYPE_MASK:    seen_mask    = csr_write_data;
               CSR_TYPE_VERSION: seen_version = csr_write_data;
               default: ;        // spare index, no effect
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_status.size() == 0) begin
               report_mismatch("rsp beat with no status pending");
            end else begin
               due = pending_status.pop_front();
               if (rsp_event_kind !== due.event_kind)
                  report_mismatch($sformatf("event_kind got %0d want %0d",
                     rsp_event_kind, due.event_kind));
               if (rsp_payload_byte !== due.payload_byte)
                  report_mismatch($sformatf("payload_byte got %h want %h",
                     rsp_payload_byte, due.payload_byte));
               if (rsp_payload_index !== due.payload_index)
                  report_mismatch($sformatf("payload_index got %0d want %0d",
                     rsp_payload_index, due.payload_index));
               if (rsp_frame_type !== due.frame_type)
                  report_mismatch($sformatf("frame_type got %h want %h",
                     rsp_frame_type, due.frame_type));
               if (rsp_frame_length !== due.frame_length)
                  report_mismatch($sformatf("frame_length got %0d want %0d",
                     rsp_frame_length, due.frame_length));
               if (rsp_object_id !== due.object_id)
                  report_mismatch($sformatf("object_id got %h want %h",
                     rsp_object_id, due.object_id));
               if (rsp_instance_id !== due.instance_id)
                  report_mismatch($sformatf("instance_id got %h want %h",
                     rsp_instance_id, due.instance_id));
            end
         end
         if (req_valid && req_ready) begin
            due = predict_status(req_rx_byte);
            pending_status.push_back(due);
            case (due.event_kind)
               EVT_PAYLOAD:  payload_beats++;
               EVT_CRC_GOOD: frames_good++;
               EVT_CRC_BAD:  frames_bad++;
               default: ;
            endcase
         end
      end
   end

   // Watchdog: any accepted beat on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d status beats pending",
            quiet_cycles, pending_status.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned send_gap_pct();
      return (pace == PACE_SEND_GAPS) ? 57 : (pace == PACE_BOTH) ? 8 : 0;
   endfunction

   function automatic int unsigned recv_stall_pct();
      return (pace == PACE_RECV_STALLS) ? 57 : (pace == PACE_BOTH) ? 8 : 0;
   endfunction

   // Receiver: ready drops at random per cycle according to the pace.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct());
   end

   // Sends one byte beat. Valid is only dropped when a gap is taken, so a
   // back-to-back beat never sees valid lowered and raised in one step.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gaps;
      gaps = 0;
      while ($urandom_range(99) < send_gap_pct()) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Sender holds off until every status beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   task automatic program_cfg(input logic [7:0] s, input logic [7:0] m, input logic [7:0] v);
      drain();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_SYNC_VALUE;
      csr_write_data <= s;
      @(posedge clock);
      csr_index      <= CSR_TYPE_MASK;
      csr_write_data <= m;
      @(posedge clock);
      csr_index      <= CSR_TYPE_VERSION;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cur_sync    = s;
      cur_mask    = m;
      cur_version = v;
      settings_used++;
   endtask

   // Type byte that passes the current version check (when one exists).
   function automatic logic [7:0] pass_type();
      return (8'($urandom) & ~cur_mask) | cur_version;
   endfunction

   // Builds a frame under the current sync value and sends its first 'keep'
   // bytes (all of them when keep is 0). An out-of-range length ends the
   // frame after the length field, as the parser drops it there.
   task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                             input logic [31:0] obj, input logic [15:0] inst,
                             input bit crc_ok, input int unsigned keep);
      logic [7:0]  frame_q[$];
      logic [7:0]  sum;
      int unsigned n;
      int unsigned i;
      frame_q = {};
      frame_q.push_back(cur_sync);
      frame_q.push_back(ftype);
      frame_q.push_back(flen[7:0]);
      frame_q.push_back(flen[15:8]);
      if (flen >= LEN_MIN && flen <= LEN_MAX) begin
         for (i = 0; i < 4; i++) frame_q.push_back(obj[8*i +: 8]);
         frame_q.push_back(inst[7:0]);
         frame_q.push_back(inst[15:8]);
         for (i = 0; i < flen - LEN_MIN; i++) frame_q.push_back(8'($urandom));
         sum = 8'h00;
         foreach (frame_q[k]) sum = crc_update(sum, frame_q[k]);
         if (!crc_ok) sum = sum ^ 8'($urandom_range(255, 1));
         frame_q.push_back(sum);
      end
      n = (keep > 0 && keep < frame_q.size()) ? keep : frame_q.size();
      for (i = 0; i < n; i++) send_byte(frame_q[i]);
   endtask

   // Mixed traffic: mostly well-formed frames with random content, the rest
   // line noise, truncated frames, foreign types and bad lengths.
   task automatic run_traffic(input int unsigned quota);
      int unsigned start;
      int unsigned pick;
      int unsigned plen;
      logic [15:0] bad_len;
      start = bytes_sent;
      while (bytes_sent - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
         end else if (pick < 12) begin
            // cut short: next frame's bytes land inside this one
            send_frame(pass_type(), 16'(LEN_MIN + $urandom_range(8)), $urandom,
               16'($urandom), 1'b1, $urandom_range(9, 2));
         end else if (pick < 18) begin
            send_frame(8'($urandom), 16'(LEN_MIN + $urandom_range(6)), $urandom,
               16'($urandom), 1'b1, 0);
         end else if (pick < 24) begin
            bad_len = $urandom_range(1) ? 16'($urandom_range(9))
                                        : 16'($urandom_range(65535, 266));
            send_frame(pass_type(), bad_len, $urandom, 16'($urandom), 1'b1, 0);
         end else begin
            plen = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(64, 13);
            send_frame(pass_type(), 16'(LEN_MIN + plen), $urandom, 16'($urandom),
               $urandom_range(99) < 80, 0);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset register values: each drop path, then a header-only frame whose
   // object id carries the sync value and all-ones instance id.
   task automatic test_directed_frames();
      pace = PACE_STEADY;
      send_frame(8'h00, 16'd20, 32'h0, 16'h0, 1'b1, 2);           // wrong type
      send_frame(8'h27, 16'd9, 32'h0, 16'h0, 1'b1, 0);            // length too short
      send_frame(8'h20, 16'd266, 32'h0, 16'h0, 1'b1, 0);          // length too long
      send_frame(8'h21, LEN_MIN, {cur_sync, 8'hFF, 8'h00, cur_sync}, 16'hFFFF, 1'b1, 0);
   endtask

   // A write to the spare index must leave all registers alone.
   task automatic test_unused_index();
      pace = PACE_STEADY;
      drain();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_SPARE;
      csr_write_data <= 8'($urandom);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      send_frame(pass_type(), 16'd13, $urandom, 16'($urandom), 1'b1, 0);
      send_frame(pass_type(), 16'd11, $urandom, 16'($urandom), 1'b0, 0);
   endtask

   // Longest payload, then the shortest frames, with the receiver stalling.
   task automatic test_length_extremes();
      pace = PACE_RECV_STALLS;
      send_frame(pass_type(), LEN_MAX, $urandom, 16'($urandom), 1'b1, 0);
      send_frame(pass_type(), LEN_MIN, $urandom, 16'($urandom), 1'b0, 0);
      send_frame(pass_type(), 16'd11, 32'hFFFFFFFF, 16'h0000, 1'b1, 0);
   endtask

   // Register extremes: accept-any-type, all ones, and a version that no
   // masked type can ever match.
   task automatic test_config_extremes();
      pace = PACE_SEND_GAPS;
      program_cfg(8'h00, 8'h00, 8'h00);
      run_traffic(60);
      program_cfg(8'hFF, 8'hFF, 8'hFF);
      run_traffic(60);
      program_cfg(8'($urandom), 8'h0F, 8'hF0);
      run_traffic(40);
   endtask

   task automatic test_random_traffic(input pace_type p, input int unsigned quota);
      logic [7:0] m;
      m = ($urandom_range(3) == 0) ? TYPE_MASK_RST : 8'($urandom);
      program_cfg(8'($urandom), m, 8'($urandom) & m);
      pace = p;
      run_traffic(quota);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_unused_index();
      test_length_extremes();
      test_config_extremes();
      test_random_traffic(PACE_STEADY, 320);
      test_random_traffic(PACE_SEND_GAPS, 320);
      test_random_traffic(PACE_RECV_STALLS, 320);
      test_random_traffic(PACE_BOTH, 320);

      // wait out the last status beats plus the result register
      drain();
      repeat (4) @(posedge clock);

      $display("covered %0d byte beats over %0d register settings and four pacing modes",
         bytes_sent, settings_used + 1);
      $display("saw %0d payload beats, %0d good-crc frames, %0d bad-crc frames",
         payload_beats, frames_good, frames_bad);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
